// ===== src/rwps_pkg.sv =====
// Shared types and constants of the retention-time window peak selector.
package rwps_pkg;

  // Table and field geometry
  localparam int unsigned TABLE_DEPTH_DEF = 1024;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned PEAK_W    = 32;
  localparam int unsigned VAL_W     = 42;
  localparam int unsigned IDX_OUT_W = 10;
  localparam int unsigned TOL_W     = 24;
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned ENTRY_W   = 3 * PEAK_W;

  // Fixed-point widths: Q16 ratios reach 1.0, so 17 bits
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned Q16_W   = FRAC_W + 1;
  localparam int unsigned SQ_W    = 2 * FRAC_W + 1;
  localparam int unsigned SCORE_W = Q16_W + 2 * FRAC_W;
  localparam int unsigned DEN_W   = SQ_W;

  localparam logic [VAL_W-1:0] VALUE_MAX = {VAL_W{1'b1}};
  localparam logic [Q16_W-1:0] Q16_ONE   = Q16_W'(1) << FRAC_W;

  // Item kinds
  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_QUERY  = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Selection modes
  localparam logic [MODE_W-1:0] MODE_NEAREST = 3'd0;
  localparam logic [MODE_W-1:0] MODE_MAX     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SUM     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_AVG     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SCORE   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_SCORE2  = 3'd5;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TOL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VSRC = 2'd2;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_P1_RD,
    S_P1_CHK,
    S_P2_RD,
    S_P2_CHK,
    S_DIST,
    S_RATIO,
    S_MUL_D,
    S_SC_CHK,
    S_SC_DIV,
    S_MUL_R,
    S_CMP2,
    S_END,
    S_AVG,
    S_FIN
  } state_e;

  // One finished result
  typedef struct packed {
    logic [1:0]           status;
    logic [IDX_OUT_W-1:0] idx;
    logic [VAL_W-1:0]     val;
  } result_t;

endpackage

// ===== src/rwps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rwps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/rwps_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
module rwps_div #(
  parameter int unsigned NUM_W = 49,
  parameter int unsigned DEN_W = 33
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int unsigned CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q, done_q;
  logic [DEN_W:0]   trial, diff;
  logic             ge;

  // trial subtract of the shifted remainder
  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        quo_q  <= num_i;
        rem_q  <= '0;
        den_q  <= den_i;
        cnt_q  <= CW'(NUM_W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        quo_q <= {quo_q[NUM_W-2:0], ge};
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== src/rt_window_peak_selector_core.sv =====
// Top level of the retention-time window peak selector.
//
// Input stream: s_axis_tuser carries the item kind (append, query, clear),
// s_axis_tdata the time, height and area. Output stream: one result per
// item, m_axis_tuser the status, m_axis_tdata the peak index and value.
// Registers (tolerance, mode, value source) are written over cfg_*, by
// the user only while the block is idle; the block does not enforce it.
//
// Sequence: append, clear and ignored items go from idle to the final
// state, which loads the output register. A query makes two passes over
// the N stored entries, with a read and a check state per entry and pass.
// Each entry inside the window needs divisions (nearest: 1, score and
// score2: 2, score a third unless the distance is zero), and in score it
// passes the squarer and check states, in score2 also the second squarer
// and compare states. Average adds a division of the sum at the end.
// The bit-serial divider and the single read port of the table set the
// time an item takes; one item is worked on at a time.
//
// Reset empties the table (entry count zero) and loads the default
// registers. A result waits in the output register while the receiver
// stalls; the next item is accepted meanwhile and holds in its last step.
module rt_window_peak_selector_core
  import rwps_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // fields from bit 0: time_value[31:0], height[63:32], area[95:64]
  input  logic [95:0]          s_axis_tdata,
  // fields from bit 0: kind[1:0]
  input  logic [1:0]           s_axis_tuser,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // fields from bit 0: peak_index[9:0], result_value[51:10], zero fill
  output logic [55:0]          m_axis_tdata,
  // fields from bit 0: status[1:0]
  output logic [1:0]           m_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [TOL_W-1:0]     cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SUM_W = PEAK_W + CNT_W;
  localparam int unsigned NUM_W = (SUM_W > SCORE_W) ? SUM_W : SCORE_W;

  state_e state_q, state_d;

  // configuration
  logic [TOL_W-1:0]  tol_q;
  logic [MODE_W-1:0] mode_q;
  logic              vsrc_q;

  // sequencer data
  logic [CNT_W-1:0]  ecount_q, i_q, wcnt_q, best_idx_q;
  logic [TIME_W-1:0] t_q, lo_q, maxh_q;
  logic [TIME_W:0]   hi_q;
  logic [PEAK_W-1:0] y_q, v_q, best_v_q;
  logic [Q16_W-1:0]  dist_q, ratio_q;
  logic [SQ_W-1:0]   d2_q, prod_q;
  logic [SUM_W-1:0]  sum_q;
  logic [SCORE_W-1:0] best_s_q;
  logic              have_q;
  result_t           res_q, out_q;
  logic              out_valid_q;

  // table and divider
  logic [ENTRY_W-1:0] rdata;
  logic [TIME_W-1:0]  rd_time;
  logic [PEAK_W-1:0]  rd_h, rd_a, rd_v;
  logic               ram_we;
  logic               div_start, div_done;
  logic [NUM_W-1:0]   div_num, div_q;
  logic [DEN_W-1:0]   div_den;

  // combinational helpers
  logic               s_hs, fin_go, full, in_win, min_mode, better;
  logic               cand_en, advance;
  logic [SCORE_W-1:0] cand_s;
  logic [PEAK_W-1:0]  cand_v;
  logic [TIME_W-1:0]  ad, in_t, tol_ext;
  logic [Q16_W-1:0]   r1, mul_a;
  logic [2*Q16_W-1:0] mul_p;
  logic [NUM_W:0]     sum_ext, q_ext;
  logic [VAL_W-1:0]   sum_sat, q_sat;

  assign in_t    = s_axis_tdata[31:0];
  assign tol_ext = TIME_W'(tol_q);
  assign s_hs    = s_axis_tvalid && s_axis_tready;
  assign fin_go  = (state_q == S_FIN) && (!out_valid_q || m_axis_tready);
  assign full    = ecount_q == CNT_W'(TABLE_DEPTH);
  assign ram_we  = s_hs && (kind_e'(s_axis_tuser) == KIND_APPEND) && !full;
  assign s_axis_tready = state_q == S_IDLE;

  assign rd_time = rdata[31:0];
  assign rd_h    = rdata[63:32];
  assign rd_a    = rdata[95:64];
  assign rd_v    = vsrc_q ? rd_a : rd_h;
  assign in_win  = (rd_time >= lo_q) && ({1'b0, rd_time} <= hi_q);
  assign ad      = (rd_time >= t_q) ? rd_time - t_q : t_q - rd_time;

  // shared squarer: dist^2, then (1 - ratio)^2
  assign r1    = Q16_ONE - ratio_q;
  assign mul_a = (state_q == S_MUL_D) ? dist_q : r1;
  assign mul_p = mul_a * mul_a;

  assign min_mode = (mode_q == MODE_NEAREST) || (mode_q == MODE_SCORE2);
  assign better   = !have_q || (min_mode ? (cand_s < best_s_q) : (cand_s > best_s_q));

  // saturation of sum and quotient to the result width
  assign sum_ext = (NUM_W+1)'(sum_q);
  assign q_ext   = (NUM_W+1)'(div_q);
  assign sum_sat = (sum_ext > (NUM_W+1)'(VALUE_MAX)) ? VALUE_MAX : sum_ext[VAL_W-1:0];
  assign q_sat   = (q_ext > (NUM_W+1)'(VALUE_MAX)) ? VALUE_MAX : q_ext[VAL_W-1:0];

  rwps_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ecount_q[IDX_W-1:0]),
    .wdata_i (s_axis_tdata),
    .raddr_i (i_q[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  rwps_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_q)
  );

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state, divider requests and candidates
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    cand_en   = 1'b0;
    cand_s    = '0;
    cand_v    = v_q;
    advance   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (s_hs) begin
          state_d = (kind_e'(s_axis_tuser) == KIND_QUERY) ? S_P1_RD : S_FIN;
        end
      end
      S_P1_RD: begin
        state_d = (i_q == ecount_q) ? S_P2_RD : S_P1_CHK;
      end
      S_P1_CHK: begin
        state_d = S_P1_RD;
      end
      S_P2_RD: begin
        state_d = (i_q == ecount_q) ? S_END : S_P2_CHK;
      end
      S_P2_CHK: begin
        cand_v = rd_v;
        if (!in_win) begin
          advance = 1'b1;
        end else if ((mode_q == MODE_MAX) || (mode_q == MODE_SUM) ||
                     (mode_q == MODE_AVG)) begin
          cand_en = 1'b1;
          cand_s  = SCORE_W'(rd_v);
          advance = 1'b1;
        end else if ((mode_q == MODE_NEAREST) || (mode_q == MODE_SCORE) ||
                     (mode_q == MODE_SCORE2)) begin
          div_start = 1'b1;
          div_num   = NUM_W'({ad, FRAC_W'(0)});
          div_den   = (tol_q == '0) ? DEN_W'(1) : DEN_W'(tol_q);
          state_d   = S_DIST;
        end else begin
          advance = 1'b1;
        end
      end
      S_DIST: begin
        if (div_done) begin
          if (mode_q == MODE_NEAREST) begin
            cand_en = 1'b1;
            cand_s  = SCORE_W'(div_q);
            advance = 1'b1;
          end else begin
            div_start = 1'b1;
            div_num   = NUM_W'({y_q, FRAC_W'(0)});
            div_den   = DEN_W'(maxh_q);
            state_d   = S_RATIO;
          end
        end
      end
      S_RATIO: begin
        if (div_done) begin
          state_d = S_MUL_D;
        end
      end
      S_MUL_D: begin
        state_d = S_SC_CHK;
      end
      S_SC_CHK: begin
        if (mode_q == MODE_SCORE2) begin
          state_d = S_MUL_R;
        end else if (d2_q == '0) begin
          // zero distance saturates to the top score
          cand_en = 1'b1;
          cand_s  = '1;
          advance = 1'b1;
        end else begin
          div_start = 1'b1;
          div_num   = NUM_W'({ratio_q, 32'd0});
          div_den   = d2_q;
          state_d   = S_SC_DIV;
        end
      end
      S_SC_DIV: begin
        if (div_done) begin
          cand_en = 1'b1;
          cand_s  = SCORE_W'(div_q);
          advance = 1'b1;
        end
      end
      S_MUL_R: begin
        state_d = S_CMP2;
      end
      S_CMP2: begin
        cand_en = 1'b1;
        cand_s  = SCORE_W'(prod_q) + SCORE_W'(d2_q);
        advance = 1'b1;
      end
      S_END: begin
        if (have_q && (mode_q == MODE_AVG)) begin
          div_start = 1'b1;
          div_num   = NUM_W'(sum_q);
          div_den   = DEN_W'(wcnt_q);
          state_d   = S_AVG;
        end else begin
          state_d = S_FIN;
        end
      end
      S_AVG: begin
        if (div_done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (advance) begin
      state_d = S_P2_RD;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q       <= TOL_W'(500);
      mode_q      <= MODE_NEAREST;
      vsrc_q      <= 1'b0;
      ecount_q    <= '0;
      out_valid_q <= 1'b0;
      have_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_TOL:  tol_q  <= cfg_data_i;
          CFG_MODE: mode_q <= cfg_data_i[MODE_W-1:0];
          CFG_VSRC: vsrc_q <= cfg_data_i[0];
          default:  ;
        endcase
      end
      if (ram_we) begin
        ecount_q <= ecount_q + CNT_W'(1);
      end else if (s_hs && (kind_e'(s_axis_tuser) == KIND_CLEAR)) begin
        ecount_q <= '0;
      end
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (s_hs) begin
        have_q <= 1'b0;
      end else if (cand_en && better) begin
        have_q <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        t_q    <= in_t;
        lo_q   <= (in_t >= tol_ext) ? in_t - tol_ext : '0;
        hi_q   <= {1'b0, in_t} + {1'b0, tol_ext};
        i_q    <= '0;
        maxh_q <= TIME_W'(1);
        sum_q  <= '0;
        wcnt_q <= '0;
        if ((kind_e'(s_axis_tuser) == KIND_APPEND) && full) begin
          res_q <= '{status: ST_FULL, idx: '0, val: '0};
        end else if (kind_e'(s_axis_tuser) == KIND_APPEND) begin
          res_q <= '{status: ST_OK, idx: IDX_OUT_W'(ecount_q), val: '0};
        end else begin
          res_q <= '{status: ST_OK, idx: '0, val: '0};
        end
      end
      S_P1_RD: begin
        if (i_q == ecount_q) begin
          i_q <= '0;
        end
      end
      S_P1_CHK: begin
        if (in_win && (rd_h > maxh_q)) begin
          maxh_q <= rd_h;
        end
        i_q <= i_q + CNT_W'(1);
      end
      S_P2_CHK: begin
        y_q <= rd_h;
        v_q <= rd_v;
        if (in_win) begin
          sum_q  <= sum_q + SUM_W'(rd_v);
          wcnt_q <= wcnt_q + CNT_W'(1);
        end
      end
      S_DIST: begin
        dist_q <= div_q[Q16_W-1:0];
      end
      S_RATIO: begin
        ratio_q <= div_q[Q16_W-1:0];
      end
      S_MUL_D: begin
        d2_q <= mul_p[SQ_W-1:0];
      end
      S_MUL_R: begin
        prod_q <= mul_p[SQ_W-1:0];
      end
      S_END: begin
        if (!have_q) begin
          res_q <= '{status: ST_EMPTY, idx: '0, val: '0};
        end else begin
          res_q.status <= ST_OK;
          res_q.idx    <= IDX_OUT_W'(best_idx_q);
          res_q.val    <= (mode_q == MODE_SUM) ? sum_sat : VAL_W'(best_v_q);
        end
      end
      S_AVG: begin
        res_q.val <= q_sat;
      end
      default: ;
    endcase
    if (advance) begin
      i_q <= i_q + CNT_W'(1);
    end
    if (cand_en && better) begin
      best_s_q   <= cand_s;
      best_idx_q <= i_q;
      best_v_q   <= cand_v;
    end
    if (fin_go) begin
      out_q <= res_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {4'd0, out_q.val, out_q.idx};

endmodule

// ===== src/rwps_checker.sv =====
// Port-level checks of the peak selector, bound to the top level.
module rwps_checker
  import rwps_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // one item at a time: an accepted request closes the input
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input open right after accept");

  // only defined status codes leave the block
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == ST_OK) || (m_axis_tuser == ST_EMPTY) ||
      (m_axis_tuser == ST_FULL))
    else $error("bad status code");

  // empty window and full table carry zero index and value
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != ST_OK) |-> m_axis_tdata == '0)
    else $error("nonzero payload on failure status");

endmodule

bind rt_window_peak_selector_core rwps_checker u_rwps_checker (.*);
